// File: rtl/cdq_pkg.sv
package cdq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_LIST       = 3'd4;

   localparam logic [1:0] STS_DONE  = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       pop_back;
      logic       list_first;
      logic       list_next;
      logic       rsp_valid;
      logic [1:0] rsp_status;
      logic       rsp_from_ram;
      logic       rsp_last;
   } cdq_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic full;
      logic occ_one;
      logic list_final;
   } cdq_sts_type;

   // (a + b) mod DEPTH, valid for a < DEPTH and b <= DEPTH
   function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

// File: rtl/cdq_ram.sv
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/cdq_datapath.sv
module cdq_datapath import cdq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cdq_cmd_type       cmd,
   input  logic [DATA_W-1:0] wr_value,
   output cdq_sts_type       sts,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [DATA_W-1:0] rsp_item_value,
   output logic              rsp_last
);

   logic [IDX_W-1:0]  front_ff, front_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic              rsp_from_ram_ff;
   logic              rsp_last_ff;

   logic [CNT_W-1:0]  wr_offset, rd_offset;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic              ram_we, ram_re;
   logic [DATA_W-1:0] ram_rdata;

   // slot offsets from the front entry
   assign wr_offset = cmd.push_front ? CNT_W'(DEPTH - 1) : occ_ff;
   assign rd_offset = cmd.pop_back  ? (occ_ff - CNT_W'(1)) :
                      cmd.list_next ? idx_ff : '0;
   assign wr_addr   = add_mod(front_ff, wr_offset);
   assign rd_addr   = add_mod(front_ff, rd_offset);
   assign ram_we    = cmd.push_front | cmd.push_back;
   assign ram_re    = cmd.pop_front | cmd.pop_back | cmd.list_first | cmd.list_next;

   cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (wr_value),
      .re    (ram_re),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      if (cmd.push_front) begin
         front_in = wr_addr;
      end
      if (cmd.pop_front) begin
         front_in = add_mod(front_ff, CNT_W'(1));
      end
      if (ram_we) begin
         occ_in = occ_ff + CNT_W'(1);
      end
      if (cmd.pop_front | cmd.pop_back) begin
         occ_in = occ_ff - CNT_W'(1);
      end
      if (cmd.list_first) begin
         idx_in = CNT_W'(1);
      end
      if (cmd.list_next) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= cmd.rsp_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= cmd.rsp_status;
      rsp_from_ram_ff <= cmd.rsp_from_ram;
      rsp_last_ff     <= cmd.rsp_last;
   end

   assign sts.empty      = (occ_ff == '0);
   assign sts.full       = (occ_ff == CNT_W'(DEPTH));
   assign sts.occ_one    = (occ_ff == CNT_W'(1));
   assign sts.list_final = ((CNT_W+1)'(idx_ff) + (CNT_W+1)'(1)) == (CNT_W+1)'(occ_ff);

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_value = rsp_from_ram_ff ? ram_rdata : '0;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: rtl/cdq_ctrl.sv
module cdq_ctrl import cdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  action,
   input  cdq_sts_type sts,
   output cdq_cmd_type cmd,
   output logic        busy
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (action)
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     cmd.rsp_valid = 1'b1;
                     cmd.rsp_last  = 1'b1;
                     if (sts.full) begin
                        cmd.rsp_status = STS_FULL;
                     end else begin
                        cmd.rsp_status = STS_DONE;
                        cmd.push_front = (action == ACT_PUSH_FRONT);
                        cmd.push_back  = (action == ACT_PUSH_BACK);
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     cmd.rsp_valid = 1'b1;
                     cmd.rsp_last  = 1'b1;
                     if (sts.empty) begin
                        cmd.rsp_status = STS_EMPTY;
                     end else begin
                        cmd.rsp_status   = STS_DONE;
                        cmd.rsp_from_ram = 1'b1;
                        cmd.pop_front    = (action == ACT_POP_FRONT);
                        cmd.pop_back     = (action == ACT_POP_BACK);
                     end
                  end
                  ACT_LIST: begin
                     cmd.rsp_valid = 1'b1;
                     if (sts.empty) begin
                        cmd.rsp_status = STS_EMPTY;
                        cmd.rsp_last   = 1'b1;
                     end else begin
                        cmd.rsp_status   = STS_DONE;
                        cmd.rsp_from_ram = 1'b1;
                        cmd.list_first   = 1'b1;
                        cmd.rsp_last     = sts.occ_one;
                        if (!sts.occ_one) begin
                           state_in = ST_LIST;
                        end
                     end
                  end
                  default: begin
                     // unused codes give no word
                  end
               endcase
            end
         end
         ST_LIST: begin
            cmd.rsp_valid    = 1'b1;
            cmd.rsp_status   = STS_DONE;
            cmd.rsp_from_ram = 1'b1;
            cmd.list_next    = 1'b1;
            cmd.rsp_last     = sts.list_final;
            if (sts.list_final) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_LIST);

endmodule

// File: rtl/circular_deque.sv
// every result word appears in the cycle after the command (ring read or write) that makes it
// push and pop never raise busy; a new word may start every cycle while busy is low
// list reads the ring once per stored entry (one ring read a cycle), busy high for all reads but the first
// an empty list, pop on empty or push on full gives a single word
// synchronous reset empties the queue; ring contents are not cleared
// the receiver cannot stall: rsp_strobe marks each result word for exactly one cycle
module circular_deque import cdq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_action,
   input  logic [DATA_W-1:0] req_value,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_status,
   output logic [DATA_W-1:0] rsp_item_value,
   output logic              rsp_last
);

   cdq_cmd_type cmd;
   cdq_sts_type sts;

   cdq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   cdq_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .wr_value       (req_value),
      .sts            (sts),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_item_value (rsp_item_value),
      .rsp_last       (rsp_last)
   );

endmodule
